[hw/rtl/whp_pkg.sv]
// Shared types and constants for the WAV header parser.
package whp_pkg;

   localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
   localparam logic [31:0] TAG_RIFX    = 32'h5846_4952;
   localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
   localparam logic [31:0] TAG_FACT    = 32'h7463_6166;
   localparam logic [15:0] FMT_PCM     = 16'h0001;
   localparam logic [15:0] FMT_EXT     = 16'hFFFE;
   localparam logic [31:0] GUID_W1     = 32'h0000_0001;
   localparam logic [31:0] GUID_W2     = 32'h0010_0000;
   localparam logic [31:0] GUID_W3     = 32'hAA00_0080;
   localparam logic [31:0] GUID_W4     = 32'h719B_3800;
   localparam logic [31:0] SIZE_STREAM = 32'h7FFF_F000;
   localparam logic [31:0] SIZE_ONES   = 32'hFFFF_FFFF;

   // warning bit positions
   localparam int W_RIFF = 0;
   localparam int W_WAVE = 1;
   localparam int W_FMT = 2;
   localparam int W_PCM_SHORT = 3;
   localparam int W_EXT_BAD = 4;
   localparam int W_GUID = 5;
   localparam int W_FORMAT = 6;
   localparam int W_CHAN0 = 7;
   localparam int W_BITS = 8;
   localparam int W_BRATE = 9;
   localparam int W_ALIGN = 10;
   localparam int W_FACT = 11;
   localparam int W_RSIZE = 12;

   typedef enum logic [23:0] {
      PH_RIFF   = 24'h000001,
      PH_RSIZE  = 24'h000002,
      PH_WAVE   = 24'h000004,
      PH_FMT    = 24'h000008,
      PH_FSIZE  = 24'h000010,
      PH_FORMAT = 24'h000020,
      PH_CHAN   = 24'h000040,
      PH_RATE   = 24'h000080,
      PH_BRATE  = 24'h000100,
      PH_ALIGN  = 24'h000200,
      PH_BITS   = 24'h000400,
      PH_EXTRA  = 24'h000800,
      PH_VALID  = 24'h001000,
      PH_CMAP   = 24'h002000,
      PH_GUID1  = 24'h004000,
      PH_GUID2  = 24'h008000,
      PH_GUID3  = 24'h010000,
      PH_GUID4  = 24'h020000,
      PH_FSKIP  = 24'h040000,
      PH_CTAG   = 24'h080000,
      PH_CSIZE  = 24'h100000,
      PH_CSKIP  = 24'h200000,
      PH_DSIZE  = 24'h400000,
      PH_DONE   = 24'h800000
   } phase_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'h01,
      S_PARSE = 8'h02,
      S_MULC  = 8'h04,
      S_CHK   = 8'h08,
      S_MULF  = 8'h10,
      S_FIN   = 8'h20,
      S_DIV   = 8'h40,
      S_EMIT  = 8'h80
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic parse;
      logic mul;
      logic chk;
      logic fin;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic fmt_hit;
      logic fin_hit;
      logic div_go;
      logic div_last;
   } status_type;

   typedef struct packed {
      logic        header_done;
      logic        stream_mode;
      logic        big_endian;
      logic [15:0] num_channels;
      logic [31:0] rate_hz;
      logic [15:0] sample_bits;
      logic [31:0] sample_count;
      logic [31:0] header_size;
      logic [13:0] warnings;
   } rsp_word_type;

endpackage

[hw/rtl/whp_req_if.sv]
// Input channel: one file byte per word.
interface whp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       first_byte;
   modport source (output valid, output byte_value, output first_byte, input ready);
   modport sink (input valid, input byte_value, input first_byte, output ready);
endinterface

[hw/rtl/whp_rsp_if.sv]
// Result channel: parse status word.
interface whp_rsp_if;
   logic        valid;
   logic        ready;
   logic        header_done;
   logic        stream_mode;
   logic        big_endian;
   logic [15:0] num_channels;
   logic [31:0] rate_hz;
   logic [15:0] sample_bits;
   logic [31:0] sample_count;
   logic [31:0] header_size;
   logic [13:0] warnings;
   modport source (output valid, output header_done, output stream_mode, output big_endian,
                   output num_channels, output rate_hz, output sample_bits,
                   output sample_count, output header_size, output warnings, input ready);
   modport sink (input valid, input header_done, input stream_mode, input big_endian,
                 input num_channels, input rate_hz, input sample_bits,
                 input sample_count, input header_size, input warnings, output ready);
endinterface

[hw/rtl/whp_ctrl.sv]
// Sequencing controller for the WAV header parser.
module whp_ctrl
   import whp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_PARSE;
         S_PARSE: begin
            if (status.fmt_hit) state_in = S_MULC;
            else if (status.fin_hit) state_in = S_MULF;
            else state_in = S_EMIT;
         end
         S_MULC:  state_in = S_CHK;
         S_CHK:   state_in = S_EMIT;
         S_MULF:  state_in = S_FIN;
         S_FIN:   state_in = status.div_go ? S_DIV : S_EMIT;
         S_DIV:   if (status.div_last) state_in = S_EMIT;
         S_EMIT:  if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load     = accept;
      cmd.parse    = (state_ff == S_PARSE);
      cmd.mul      = (state_ff == S_MULC) || (state_ff == S_MULF);
      cmd.chk      = (state_ff == S_CHK);
      cmd.fin      = (state_ff == S_FIN);
      cmd.div_step = (state_ff == S_DIV);
      cmd.emit     = (state_ff == S_EMIT) && slot_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/whp_datapath.sv]
// Parse registers, field assembly, format checks and sample count divider.
module whp_datapath
   import whp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic [7:0]   byte_value,
   input  logic         first_byte,
   output status_type   status,
   output rsp_word_type rsp_word
);

   phase_type    phase_ff, phase_in;
   logic [2:0]   idx_ff, idx_in;
   logic [31:0]  asm_ff, asm_in;
   logic [31:0]  tag_ff, tag_in;
   logic [31:0]  skip_ff, skip_in;
   logic [31:0]  cons_ff, cons_in;
   logic [31:0]  riff_ff, riff_in;
   logic [31:0]  fsize_ff, fsize_in;
   logic [15:0]  fmt_ff, fmt_in;
   logic [15:0]  chan_ff, chan_in;
   logic [31:0]  rate_ff, rate_in;
   logic [31:0]  brate_ff, brate_in;
   logic [15:0]  align_ff, align_in;
   logic [15:0]  bits_ff, bits_in;
   logic [31:0]  dsize_ff, dsize_in;
   logic [13:0]  warn_ff, warn_in;
   logic         rifx_ff, rifx_in;
   logic [31:0]  count_ff, count_in;
   logic [31:0]  rem_ff, rem_in;
   logic [4:0]   dcnt_ff, dcnt_in;
   logic [31:0]  prod_a_ff, prod_a_in;
   logic [31:0]  prod_b_ff, prod_b_in;
   logic [7:0]   byte_ff;
   logic         first_ff;
   rsp_word_type rsp_ff;

   logic         stream;
   logic [28:0]  divisor;
   logic [31:0]  exp_rate;
   logic [32:0]  rem_sh;
   logic         rem_ge;
   logic [34:0]  diff;

   assign divisor = prod_b_ff[31:3];
   assign exp_rate = 32'(prod_a_ff[31:3] * chan_ff);
   assign stream = (riff_ff == '0) || (riff_ff == SIZE_ONES) || (dsize_ff == '0) ||
                   (dsize_ff == SIZE_ONES) || (dsize_ff == SIZE_STREAM);
   assign rem_sh = {rem_ff, count_ff[31]};
   assign rem_ge = rem_sh >= {4'b0, divisor};
   assign diff = {3'b0, cons_ff} - 35'd8 + {3'b0, dsize_ff} - {3'b0, riff_ff};

   always_comb begin
      logic        be;
      logic [2:0]  nbytes;
      logic [31:0] v;
      logic [2:0]  idx_nx;
      logic        done_f;
      logic        takes;

      phase_in = phase_ff; idx_in = idx_ff; asm_in = asm_ff; tag_in = tag_ff;
      skip_in = skip_ff; cons_in = cons_ff; riff_in = riff_ff; fsize_in = fsize_ff;
      fmt_in = fmt_ff; chan_in = chan_ff; rate_in = rate_ff; brate_in = brate_ff;
      align_in = align_ff; bits_in = bits_ff; dsize_in = dsize_ff; warn_in = warn_ff;
      rifx_in = rifx_ff; count_in = count_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      prod_a_in = prod_a_ff; prod_b_in = prod_b_ff;

      status.div_go   = !stream && (divisor != '0);
      status.div_last = (dcnt_ff == 5'd31);

      // restart on the first byte of a file
      if (first_ff) begin
         phase_in = PH_RIFF; idx_in = '0; asm_in = '0; tag_in = '0; skip_in = '0;
         cons_in = '0; riff_in = '0; fsize_in = '0; fmt_in = '0; chan_in = '0;
         rate_in = '0; brate_in = '0; align_in = '0; bits_in = '0; dsize_in = '0;
         warn_in = '0; rifx_in = 1'b0; count_in = '0;
      end

      takes = !(phase_in == PH_FSKIP || phase_in == PH_CSKIP || phase_in == PH_DONE);
      nbytes = (phase_in == PH_FORMAT || phase_in == PH_CHAN || phase_in == PH_ALIGN ||
                phase_in == PH_BITS || phase_in == PH_EXTRA || phase_in == PH_VALID)
               ? 3'd2 : 3'd4;
      be = rifx_in && !(phase_in == PH_RIFF || phase_in == PH_WAVE ||
                        phase_in == PH_FMT || phase_in == PH_CTAG);
      v = be ? {asm_in[23:0], byte_ff} :
               (asm_in | ({24'b0, byte_ff} << {idx_in[1:0], 3'b000}));
      idx_nx = idx_in + 3'd1;
      done_f = idx_nx >= nbytes;

      status.fmt_hit = (phase_in == PH_BITS) && done_f;
      status.fin_hit = (phase_in == PH_DSIZE) && done_f;

      if (cmd.parse && phase_in != PH_DONE) begin
         if (cons_in != SIZE_ONES) cons_in = cons_in + 32'd1;
         if (takes) begin
            if (done_f) begin
               asm_in = '0;
               idx_in = '0;
            end else begin
               asm_in = v;
               idx_in = idx_nx;
            end
         end
         unique case (phase_in)
            PH_RIFF: if (done_f) begin
               if (v == TAG_RIFX) rifx_in = 1'b1;
               else if (v != TAG_RIFF) warn_in[W_RIFF] = 1'b1;
               phase_in = PH_RSIZE;
            end
            PH_RSIZE: if (done_f) begin riff_in = v; phase_in = PH_WAVE; end
            PH_WAVE: if (done_f) begin
               if (v != TAG_WAVE) warn_in[W_WAVE] = 1'b1;
               phase_in = PH_FMT;
            end
            PH_FMT: if (done_f) begin
               if (v != TAG_FMT) warn_in[W_FMT] = 1'b1;
               phase_in = PH_FSIZE;
            end
            PH_FSIZE: if (done_f) begin fsize_in = v; phase_in = PH_FORMAT; end
            PH_FORMAT: if (done_f) begin fmt_in = v[15:0]; phase_in = PH_CHAN; end
            PH_CHAN: if (done_f) begin chan_in = v[15:0]; phase_in = PH_RATE; end
            PH_RATE: if (done_f) begin rate_in = v; phase_in = PH_BRATE; end
            PH_BRATE: if (done_f) begin brate_in = v; phase_in = PH_ALIGN; end
            PH_ALIGN: if (done_f) begin align_in = v[15:0]; phase_in = PH_BITS; end
            PH_BITS: if (done_f) begin
               bits_in = v[15:0];
               if (fmt_in == FMT_EXT) phase_in = PH_EXTRA;
               else if (fsize_in > 32'd16) begin
                  skip_in = fsize_in - 32'd16;
                  phase_in = PH_FSKIP;
               end else phase_in = PH_CTAG;
            end
            PH_EXTRA: if (done_f) begin
               if (fsize_in < 32'd40 || v[15:0] < 16'd22) warn_in[W_EXT_BAD] = 1'b1;
               phase_in = PH_VALID;
            end
            PH_VALID: if (done_f) phase_in = PH_CMAP;
            PH_CMAP: if (done_f) phase_in = PH_GUID1;
            PH_GUID1: if (done_f) begin
               if (v != GUID_W1) warn_in[W_GUID] = 1'b1;
               phase_in = PH_GUID2;
            end
            PH_GUID2: if (done_f) begin
               if (v != GUID_W2) warn_in[W_GUID] = 1'b1;
               phase_in = PH_GUID3;
            end
            PH_GUID3: if (done_f) begin
               if (v != GUID_W3) warn_in[W_GUID] = 1'b1;
               phase_in = PH_GUID4;
            end
            PH_GUID4: if (done_f) begin
               if (v != GUID_W4) warn_in[W_GUID] = 1'b1;
               if (fsize_in > 32'd40) begin
                  skip_in = fsize_in - 32'd40;
                  phase_in = PH_FSKIP;
               end else phase_in = PH_CTAG;
            end
            PH_FSKIP, PH_CSKIP: begin
               if (skip_in <= 32'd1) begin
                  skip_in = '0;
                  phase_in = PH_CTAG;
               end else skip_in = skip_in - 32'd1;
            end
            PH_CTAG: if (done_f) begin
               tag_in = v;
               phase_in = (v == TAG_DATA) ? PH_DSIZE : PH_CSIZE;
            end
            PH_CSIZE: if (done_f) begin
               if (tag_in == TAG_FACT && v != 32'd4) warn_in[W_FACT] = 1'b1;
               skip_in = v;
               phase_in = (v != '0) ? PH_CSKIP : PH_CTAG;
            end
            PH_DSIZE: if (done_f) begin dsize_in = v; phase_in = PH_DONE; end
            default: ;
         endcase
      end

      if (!cmd.parse) begin
         // only a parse step applies the file restart
         phase_in = phase_ff; idx_in = idx_ff; asm_in = asm_ff; tag_in = tag_ff;
         skip_in = skip_ff; cons_in = cons_ff; riff_in = riff_ff; fsize_in = fsize_ff;
         fmt_in = fmt_ff; chan_in = chan_ff; rate_in = rate_ff; brate_in = brate_ff;
         align_in = align_ff; bits_in = bits_ff; dsize_in = dsize_ff; warn_in = warn_ff;
         rifx_in = rifx_ff; count_in = count_ff;
      end

      if (cmd.mul) begin
         prod_a_in = 32'(rate_ff * bits_ff);
         prod_b_in = chan_ff * bits_ff;
      end

      if (cmd.chk) begin
         if (fmt_ff == FMT_PCM) begin
            if (fsize_ff < 32'd16) warn_in[W_PCM_SHORT] = 1'b1;
         end else if (fmt_ff != FMT_EXT) warn_in[W_FORMAT] = 1'b1;
         if (chan_ff == '0) warn_in[W_CHAN0] = 1'b1;
         if (bits_ff != 16'd16) warn_in[W_BITS] = 1'b1;
         if (brate_ff != exp_rate) warn_in[W_BRATE] = 1'b1;
         if ({16'b0, align_ff} != {3'b0, divisor}) warn_in[W_ALIGN] = 1'b1;
      end

      if (cmd.fin) begin
         count_in = '0;
         if (!stream) begin
            if ($signed(diff) > 35'sd1 || $signed(diff) < -35'sd1) warn_in[W_RSIZE] = 1'b1;
            if (divisor != '0) begin
               count_in = dsize_ff;
               rem_in = '0;
               dcnt_in = '0;
            end
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_ge ? 32'(rem_sh - {4'b0, divisor}) : rem_sh[31:0];
         count_in = {count_ff[30:0], rem_ge};
         dcnt_in = dcnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF; idx_ff <= '0; asm_ff <= '0; tag_ff <= '0; skip_ff <= '0;
         cons_ff <= '0; riff_ff <= '0; fsize_ff <= '0; fmt_ff <= '0; chan_ff <= '0;
         rate_ff <= '0; brate_ff <= '0; align_ff <= '0; bits_ff <= '0; dsize_ff <= '0;
         warn_ff <= '0; rifx_ff <= 1'b0; count_ff <= '0; rem_ff <= '0; dcnt_ff <= '0;
         first_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; idx_ff <= idx_in; asm_ff <= asm_in; tag_ff <= tag_in;
         skip_ff <= skip_in; cons_ff <= cons_in; riff_ff <= riff_in; fsize_ff <= fsize_in;
         fmt_ff <= fmt_in; chan_ff <= chan_in; rate_ff <= rate_in; brate_ff <= brate_in;
         align_ff <= align_in; bits_ff <= bits_in; dsize_ff <= dsize_in;
         warn_ff <= warn_in; rifx_ff <= rifx_in; count_ff <= count_in; rem_ff <= rem_in;
         dcnt_ff <= dcnt_in;
         if (cmd.load) first_ff <= first_byte;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      if (cmd.load) byte_ff <= byte_value;
      if (cmd.emit) begin
         rsp_ff.header_done  <= (phase_ff == PH_DONE);
         rsp_ff.stream_mode  <= (phase_ff == PH_DONE) && stream;
         rsp_ff.big_endian   <= rifx_ff;
         rsp_ff.num_channels <= chan_ff;
         rsp_ff.rate_hz      <= rate_ff;
         rsp_ff.sample_bits  <= bits_ff;
         rsp_ff.sample_count <= (phase_ff == PH_DONE) ? count_ff : '0;
         rsp_ff.header_size  <= (phase_ff == PH_DONE) ? cons_ff : '0;
         rsp_ff.warnings     <= warn_ff;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

[hw/rtl/wav_header_parser_top.sv]
// Top level of the byte-serial RIFF/RIFX WAV header parser.
//
// One word on req_chan carries one byte of a WAV file; first_byte restarts the
// parse. Every accepted word yields exactly one status word on rsp_chan with
// the fields read so far, sticky warnings, and, once the data chunk size has
// been consumed, header_done with header length, stream mode and sample count.
// Bytes after the header are absorbed and the outputs hold until the next
// first_byte. A RIFX file has its numeric fields read big-endian.
// Sequence: an ordinary byte passes accept in idle, a parse step and result
// capture. The last byte of the fmt fields adds a product step and a check
// step for the format checks; the byte rate and block align checks go through
// the shared product registers. When a sample count is formed, the last data
// size byte adds a product step, a final check step and the radix-2 divider,
// one quotient bit per cycle; in stream mode or with a zero divisor the divider
// is skipped. A finished word waits in the output register, so the next byte is
// taken while the consumer stalls; only the capture of the following result
// waits until the register frees.
module wav_header_parser_top
   import whp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   whp_req_if.sink   req_chan,
   whp_rsp_if.source rsp_chan
);

   cmd_type      cmd;
   status_type   status;
   rsp_word_type rsp_word;

   whp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   whp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .byte_value (req_chan.byte_value),
      .first_byte (req_chan.first_byte),
      .status     (status),
      .rsp_word   (rsp_word)
   );

   assign rsp_chan.header_done  = rsp_word.header_done;
   assign rsp_chan.stream_mode  = rsp_word.stream_mode;
   assign rsp_chan.big_endian   = rsp_word.big_endian;
   assign rsp_chan.num_channels = rsp_word.num_channels;
   assign rsp_chan.rate_hz      = rsp_word.rate_hz;
   assign rsp_chan.sample_bits  = rsp_word.sample_bits;
   assign rsp_chan.sample_count = rsp_word.sample_count;
   assign rsp_chan.header_size  = rsp_word.header_size;
   assign rsp_chan.warnings     = rsp_word.warnings;

   // a stalled result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> (rsp_chan.valid && $stable(rsp_word)))
      else $error("result word changed while stalled");

   // one byte in flight at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second byte accepted during processing");

   // no result appears in the cycle right after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !$rose(rsp_chan.valid))
      else $error("result appeared one cycle after accept");

   // sample count is only reported with a finished header
   a_count_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.header_done) |-> (rsp_chan.sample_count == '0))
      else $error("sample count before header done");

endmodule
